[rtl/nbsg_pkg.sv]
// Package: shared types, constants and coefficient tables of the noise-burst generator.
`timescale 1ns / 1ps
`default_nettype none
package nbsg_pkg;

    typedef enum logic [1:0] {
        MODE_CMD    = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_SAMPLE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VOICE,
        S_LP,
        S_HP,
        S_BAND,
        S_MIX,
        S_LEVEL,
        S_DECAY,
        S_SCALE
    } t_eng_state;

    // Command nibbles
    localparam logic [3:0] CMD_TRIG0  = 4'h1;
    localparam logic [3:0] CMD_TRIG1  = 4'h2;
    localparam logic [3:0] CMD_ARGS4A = 4'h3;
    localparam logic [3:0] CMD_ARGS4B = 4'h4;
    localparam logic [3:0] CMD_ARGS5  = 4'h6;

    localparam int AUDIO_W = 20;
    localparam int ENV_W   = 25;
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [15:0]      LFSR_TAPS  = 16'hB400;
    localparam logic [ENV_W-1:0] ENV_ONE    = 25'd16777216;
    localparam logic [ENV_W-1:0] ENV_CUTOFF = 25'(16777216 / 1000);
    localparam logic signed [AUDIO_W-1:0] OUT_MAX = 20'sd524287;
    localparam logic signed [AUDIO_W-1:0] OUT_MIN = -20'sd524288;

    typedef struct packed {
        logic       arm;
        logic [1:0] trig;
    } t_arm_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    function automatic logic [15:0] seed(input logic v, input logic [1:0] c);
        logic [15:0] r;
        case ({v, c})
            3'b000:  r = 16'hACE1;
            3'b001:  r = 16'h1234;
            3'b010:  r = 16'h7FFF;
            3'b100:  r = 16'h5A5A;
            3'b101:  r = 16'hBEEF;
            3'b110:  r = 16'h0F1E;
            default: r = 16'h0001;
        endcase
        return r;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] lp_coef(input logic [1:0] c);
        logic signed [MUL_B_W-1:0] r;
        case (c)
            2'd0:    r = 18'sd57195;
            2'd1:    r = 18'sd23895;
            default: r = 18'sd12208;
        endcase
        return r;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] hp_coef(input logic [1:0] c);
        logic signed [MUL_B_W-1:0] r;
        case (c)
            2'd0:    r = 18'sd23407;
            2'd1:    r = 18'sd5722;
            default: r = 18'sd1918;
        endcase
        return r;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] band_weight(input logic v,
                                                              input logic [1:0] c);
        logic signed [MUL_B_W-1:0] r;
        case ({v, c})
            3'b000:  r = 18'sd1;
            3'b001:  r = 18'sd14;
            3'b010:  r = 18'sd241;
            3'b100:  r = 18'sd18;
            3'b101:  r = 18'sd158;
            default: r = 18'sd80;
        endcase
        return r;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] voice_level(input logic v);
        return v ? 18'sd7 : 18'sd16;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] voice_decay(input logic v);
        return v ? 18'sd65534 : 18'sd65530;
    endfunction

endpackage
`default_nettype wire

[rtl/nbsg_if.sv]
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface nbsg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] cmd_byte;
    modport source (output valid, output mode, output cmd_byte, input ready);
    modport sink   (input valid, input mode, input cmd_byte, output ready);
endinterface

interface nbsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] audio_out;
    logic [1:0]         voices_sounding;
    modport source (output valid, output audio_out, output voices_sounding, input ready);
    modport sink   (input valid, input audio_out, input voices_sounding, output ready);
endinterface
`default_nettype wire

[rtl/nbsg_decoder.sv]
// Command decoder: parameter-byte countdown and pending trigger bits.
`timescale 1ns / 1ps
`default_nettype none
module nbsg_decoder (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_mode,
    input  wire logic [7:0]         i_cmd_byte,
    output nbsg_pkg::t_arm_ctrl     o_arm
);
    logic [1:0] r_trig, n_trig;
    logic [2:0] r_args, n_args;

    always_comb begin
        n_trig = r_trig;
        n_args = r_args;
        if (i_accept && i_mode == nbsg_pkg::MODE_CMD) begin
            if (r_args != 3'd0) begin
                n_args = r_args - 3'd1;
            end else begin
                case (i_cmd_byte[7:4])
                    nbsg_pkg::CMD_TRIG0:  n_trig = r_trig | 2'b01;
                    nbsg_pkg::CMD_TRIG1:  n_trig = r_trig | 2'b10;
                    nbsg_pkg::CMD_ARGS4A: n_args = 3'd4;
                    nbsg_pkg::CMD_ARGS4B: n_args = 3'd4;
                    nbsg_pkg::CMD_ARGS5:  n_args = 3'd5;
                    default: ;
                endcase
            end
        end else if (i_accept && i_mode == nbsg_pkg::MODE_ARM) begin
            n_trig = 2'b00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig <= 2'b00;
            r_args <= 3'd0;
        end else begin
            r_trig <= n_trig;
            r_args <= n_args;
        end
    end

    assign o_arm.arm  = i_accept && i_mode == nbsg_pkg::MODE_ARM;
    assign o_arm.trig = r_trig;
endmodule
`default_nettype wire

[rtl/nbsg_engine.sv]
// Voice engine: sequencer around one shared multiplier, LFSRs, filters, envelopes.
`timescale 1ns / 1ps
`default_nettype none
module nbsg_engine #(
    parameter int HOLD_PERIOD = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  nbsg_pkg::t_arm_ctrl            i_arm,
    input  wire logic [3:0]                i_scale,
    output nbsg_pkg::t_eng_stat            o_stat,
    output logic signed [19:0]             o_audio,
    output logic [1:0]                     o_sounding
);
    localparam int HW = $clog2(HOLD_PERIOD);
    localparam logic [HW:0] PER0 = (HW+1)'(HOLD_PERIOD);
    localparam logic [HW:0] PER1 = (HW+1)'(HOLD_PERIOD / 2);
    localparam int AW = nbsg_pkg::MUL_A_W;
    localparam int BW = nbsg_pkg::MUL_B_W;
    localparam int PW = nbsg_pkg::PROD_W;

    nbsg_pkg::t_eng_state r_state, n_state;

    logic                         r_v;
    logic [1:0]                   r_c;
    logic [15:0]                  r_noise [6];
    logic [3:0]                   r_nib   [6];
    logic signed [15:0]           r_lp    [6];
    logic signed [15:0]           r_hp    [6];
    logic [HW-1:0]                r_hold  [2];
    logic [nbsg_pkg::ENV_W-1:0]   r_env   [2];
    logic signed [17:0]           r_mix;
    logic signed [17:0]           r_vmix;
    logic signed [19:0]           r_total;
    logic signed [19:0]           r_audio;

    logic [2:0]                   w_k;
    logic signed [4:0]            w_nc;
    logic signed [12:0]           w_x;
    logic signed [17:0]           w_xd;
    logic signed [17:0]           w_band;
    logic signed [AW-1:0]         w_a;
    logic signed [BW-1:0]         w_b;
    logic signed [PW-1:0]         w_prod;
    logic [HW:0]                  w_hold_inc;
    logic [HW:0]                  w_per;
    logic [nbsg_pkg::ENV_W-1:0]   w_env_dec;

    assign w_k    = 3'(r_c) + (r_v ? 3'd3 : 3'd0);
    assign w_nc   = $signed({1'b0, r_nib[w_k]}) - 5'sd8;
    assign w_x    = {w_nc, 8'b0};
    assign w_xd   = 18'(w_x) - 18'(r_lp[w_k]);
    assign w_band = 18'(r_lp[w_k]) - 18'(r_hp[w_k]);
    assign w_per  = r_v ? PER1 : PER0;
    assign w_hold_inc = {1'b0, r_hold[r_v]} + (HW+1)'(1);
    assign w_env_dec  = w_prod[16 +: nbsg_pkg::ENV_W];

    // shared multiplier operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            nbsg_pkg::S_LP: begin
                w_a = AW'(w_xd);
                w_b = nbsg_pkg::lp_coef(r_c);
            end
            nbsg_pkg::S_HP: begin
                w_a = AW'(w_band);
                w_b = nbsg_pkg::hp_coef(r_c);
            end
            nbsg_pkg::S_BAND: begin
                w_a = AW'(w_band);
                w_b = nbsg_pkg::band_weight(r_v, r_c);
            end
            nbsg_pkg::S_MIX: begin
                w_a = $signed({2'b00, r_env[r_v]});
                w_b = r_mix;
            end
            nbsg_pkg::S_LEVEL: begin
                w_a = AW'(r_vmix);
                w_b = nbsg_pkg::voice_level(r_v);
            end
            nbsg_pkg::S_DECAY: begin
                w_a = $signed({2'b00, r_env[r_v]});
                w_b = nbsg_pkg::voice_decay(r_v);
            end
            nbsg_pkg::S_SCALE: begin
                w_a = AW'(r_total);
                w_b = $signed({14'b0, i_scale});
            end
            default: ;
        endcase
    end

    assign w_prod = w_a * w_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            nbsg_pkg::S_IDLE:  if (i_start) n_state = nbsg_pkg::S_VOICE;
            nbsg_pkg::S_VOICE: begin
                if (r_env[r_v] != '0) begin
                    n_state = nbsg_pkg::S_LP;
                end else if (r_v) begin
                    n_state = nbsg_pkg::S_SCALE;
                end
            end
            nbsg_pkg::S_LP:    n_state = nbsg_pkg::S_HP;
            nbsg_pkg::S_HP:    n_state = nbsg_pkg::S_BAND;
            nbsg_pkg::S_BAND:  n_state = (r_c == 2'd2) ? nbsg_pkg::S_MIX : nbsg_pkg::S_LP;
            nbsg_pkg::S_MIX:   n_state = nbsg_pkg::S_LEVEL;
            nbsg_pkg::S_LEVEL: n_state = nbsg_pkg::S_DECAY;
            nbsg_pkg::S_DECAY: n_state = r_v ? nbsg_pkg::S_SCALE : nbsg_pkg::S_VOICE;
            nbsg_pkg::S_SCALE: n_state = nbsg_pkg::S_IDLE;
            default:           n_state = nbsg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nbsg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [15:0] l;
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_noise[i] <= nbsg_pkg::seed(i >= 3, 2'(i % 3));
                r_nib[i]   <= 4'd8;
                r_lp[i]    <= '0;
                r_hp[i]    <= '0;
            end
            for (int v = 0; v < 2; v++) begin
                r_hold[v] <= '0;
                r_env[v]  <= '0;
            end
            r_v     <= 1'b0;
            r_c     <= 2'd0;
            r_mix   <= '0;
            r_vmix  <= '0;
            r_total <= '0;
            r_audio <= '0;
        end else begin
            case (r_state)
                nbsg_pkg::S_IDLE: begin
                    if (i_arm.arm) begin
                        for (int v = 0; v < 2; v++) begin
                            if (i_arm.trig[v]) begin
                                r_env[v]  <= nbsg_pkg::ENV_ONE;
                                r_hold[v] <= '0;
                            end
                        end
                    end
                    if (i_start) begin
                        r_v     <= 1'b0;
                        r_total <= '0;
                    end
                end
                nbsg_pkg::S_VOICE: begin
                    if (r_env[r_v] != '0) begin
                        // new noise nibbles at the start of each hold period
                        if (r_hold[r_v] == '0) begin
                            for (int i = 0; i < 6; i++) begin
                                if ((i >= 3) == r_v) begin
                                    l = (r_noise[i] >> 1) ^
                                        (r_noise[i][0] ? nbsg_pkg::LFSR_TAPS : 16'h0000);
                                    r_noise[i] <= l;
                                    r_nib[i]   <= l[3:0];
                                end
                            end
                        end
                        r_hold[r_v] <= (w_hold_inc >= w_per) ? '0 : w_hold_inc[HW-1:0];
                        r_mix <= '0;
                        r_c   <= 2'd0;
                    end else if (!r_v) begin
                        r_v <= 1'b1;
                    end
                end
                nbsg_pkg::S_LP: r_lp[w_k] <= 16'(PW'(r_lp[w_k]) + (w_prod >>> 16));
                nbsg_pkg::S_HP: r_hp[w_k] <= 16'(PW'(r_hp[w_k]) + (w_prod >>> 16));
                nbsg_pkg::S_BAND: begin
                    r_mix <= r_mix + 18'(w_prod >>> 8);
                    r_c   <= r_c + 2'd1;
                end
                nbsg_pkg::S_MIX:   r_vmix  <= 18'(w_prod >>> 24);
                nbsg_pkg::S_LEVEL: r_total <= r_total + 20'(w_prod >>> 4);
                nbsg_pkg::S_DECAY: begin
                    r_env[r_v] <= (w_env_dec < nbsg_pkg::ENV_CUTOFF) ? '0 : w_env_dec;
                    r_v <= 1'b1;
                end
                nbsg_pkg::S_SCALE: begin
                    if (w_prod > PW'(nbsg_pkg::OUT_MAX)) begin
                        r_audio <= nbsg_pkg::OUT_MAX;
                    end else if (w_prod < PW'(nbsg_pkg::OUT_MIN)) begin
                        r_audio <= nbsg_pkg::OUT_MIN;
                    end else begin
                        r_audio <= w_prod[19:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stat.busy = r_state != nbsg_pkg::S_IDLE;
    assign o_stat.done = r_state == nbsg_pkg::S_SCALE;
    assign o_audio     = (r_state == nbsg_pkg::S_SCALE) ?
                         ((w_prod > PW'(nbsg_pkg::OUT_MAX)) ? nbsg_pkg::OUT_MAX :
                          (w_prod < PW'(nbsg_pkg::OUT_MIN)) ? nbsg_pkg::OUT_MIN :
                          w_prod[19:0]) : r_audio;
    assign o_sounding  = {r_env[1] != '0, r_env[0] != '0};
endmodule
`default_nettype wire

[rtl/noise_burst_sound_generator_unit.sv]
// Top level: APB register, handshakes, result register, decoder and voice engine.
//
//  channel   dir   payload                              handshake
//  i_in_ch   in    mode[1:0], cmd_byte[7:0]             valid/ready
//  o_out_ch  out   audio_out[19:0] s, voices_sounding   valid/ready
//  apb       in    channel_scale at 0x0                 psel/penable, pready=1
//
// Command and arm items finish in the accept cycle; the result shows next cycle.
// A sample item runs the multiply sequencer: per sounding voice three bands of LP, HP
// and band weight, then mix, level, decay; then output scaling; all on one multiplier.
// Synchronous active-low reset: voices silent, LFSRs seeded, channel_scale = 10.
// Input is held off while the sequencer runs or while a result waits unread.
`timescale 1ns / 1ps
`default_nettype none
module noise_burst_sound_generator_unit #(
    parameter int HOLD_PERIOD = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    nbsg_in_if.sink          i_in_ch,
    nbsg_out_if.source       o_out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [3:0]               r_scale;
    logic                     r_out_valid;
    logic signed [19:0]       r_audio;
    logic [1:0]               r_sounding;
    logic                     w_in_ready;
    logic                     w_accept;
    logic                     w_start;
    nbsg_pkg::t_arm_ctrl      w_arm;
    nbsg_pkg::t_eng_stat      w_stat;
    logic signed [19:0]       w_eng_audio;
    logic [1:0]               w_eng_sounding;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'b0, r_scale} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 4'd10;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_scale <= pwdata[3:0];
        end
    end

    assign w_in_ready = !w_stat.busy && (!r_out_valid || o_out_ch.ready);
    assign w_accept   = i_in_ch.valid && w_in_ready;
    assign w_start    = w_accept && i_in_ch.mode == nbsg_pkg::MODE_SAMPLE;
    assign i_in_ch.ready = w_in_ready;

    nbsg_decoder u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_mode     (i_in_ch.mode),
        .i_cmd_byte (i_in_ch.cmd_byte),
        .o_arm      (w_arm)
    );

    nbsg_engine #(.HOLD_PERIOD(HOLD_PERIOD)) u_eng (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_arm      (w_arm),
        .i_scale    (r_scale),
        .o_stat     (w_stat),
        .o_audio    (w_eng_audio),
        .o_sounding (w_eng_sounding)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done || (w_accept && !w_start)) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_audio    <= w_eng_audio;
            r_sounding <= w_eng_sounding;
        end else if (w_accept && !w_start) begin
            r_audio    <= '0;
            // arming turns on the pending voices
            r_sounding <= (i_in_ch.mode == nbsg_pkg::MODE_ARM) ?
                          (w_eng_sounding | w_arm.trig) : w_eng_sounding;
        end
    end

    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.audio_out       = r_audio;
    assign o_out_ch.voices_sounding = r_sounding;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_stat.busy)
        else $error("sample transfer did not start the sequencer");

    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> !r_out_valid)
        else $error("sequencer finished while a result was still pending");

    a_env_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_stat.busy && !w_accept) |=> $stable(w_eng_sounding))
        else $error("voice envelopes changed with no transfer in flight");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !i_in_ch.ready)
        else $error("input ready while the sequencer runs");
endmodule
`default_nettype wire

[tb/sv/noise_burst_sound_generator_unit_tb.sv]
// Testbench: noise-burst generator driven with command/arm/sample items, checked by a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module noise_burst_sound_generator_unit_tb;

    class nbsg_scoreboard;
        logic [3:0]  gain;
        logic [1:0]  pend_trig;
        logic [2:0]  skip_cnt;
        logic [15:0] lfsr[6];
        logic [3:0]  nib[6];
        longint      lp_st[6];
        longint      hp_st[6];
        int          hold_cnt[2];
        longint      env[2];
        logic signed [19:0] exp_audio[$];
        logic [1:0]         exp_snd[$];
        int          errors;

        function new();
            errors = 0;
            init_state();
        endfunction

        function void init_state();
            logic [15:0] seeds[6];
            seeds = '{16'hACE1, 16'h1234, 16'h7FFF, 16'h5A5A, 16'hBEEF, 16'h0F1E};
            gain = 4'd10;
            pend_trig = 2'b00;
            skip_cnt = 3'd0;
            for (int k = 0; k < 6; k++) begin
                lfsr[k] = seeds[k];
                nib[k] = 4'd8;
                lp_st[k] = 0;
                hp_st[k] = 0;
            end
            hold_cnt = '{0, 0};
            env = '{0, 0};
        endfunction

        // arithmetic shift is floor division for longint
        function longint voice_sample(int v);
            int     lpc[3];
            int     hpc[3];
            int     wt[3];
            int     period;
            longint mix;
            longint x;
            longint lp;
            longint hp;
            int     k;
            lpc = '{57195, 23895, 12208};
            hpc = '{23407, 5722, 1918};
            if (v == 0) wt = '{1, 14, 241};
            else wt = '{18, 158, 80};
            period = (v == 0) ? 16 : 8;
            mix = 0;
            if (hold_cnt[v] == 0) begin
                for (int c = 0; c < 3; c++) begin
                    k = v * 3 + c;
                    lfsr[k] = (lfsr[k] >> 1) ^ (lfsr[k][0] ? nbsg_pkg::LFSR_TAPS : 16'h0);
                    nib[k] = lfsr[k][3:0];
                end
            end
            hold_cnt[v]++;
            if (hold_cnt[v] >= period) hold_cnt[v] = 0;
            for (int c = 0; c < 3; c++) begin
                k = v * 3 + c;
                x = (longint'(nib[k]) - 8) * 256;
                lp = lp_st[k];
                hp = hp_st[k];
                lp += ((x - lp) * lpc[c]) >>> 16;
                hp += ((lp - hp) * hpc[c]) >>> 16;
                lp_st[k] = lp;
                hp_st[k] = hp;
                mix += ((lp - hp) * wt[c]) >>> 8;
            end
            mix = (mix * env[v]) >>> 24;
            env[v] = (env[v] * ((v == 0) ? 65530 : 65534)) >>> 16;
            if (env[v] < 16777) env[v] = 0;
            return (mix * ((v == 0) ? 16 : 7)) >>> 4;
        endfunction

        function void note_item(logic [1:0] mode, logic [7:0] b);
            longint total;
            total = 0;
            if (mode == nbsg_pkg::MODE_CMD) begin
                if (skip_cnt > 0) skip_cnt--;
                else case (b[7:4])
                    nbsg_pkg::CMD_TRIG0: pend_trig[0] = 1'b1;
                    nbsg_pkg::CMD_TRIG1: pend_trig[1] = 1'b1;
                    nbsg_pkg::CMD_ARGS4A, nbsg_pkg::CMD_ARGS4B: skip_cnt = 3'd4;
                    nbsg_pkg::CMD_ARGS5: skip_cnt = 3'd5;
                    default: ;
                endcase
            end else if (mode == nbsg_pkg::MODE_ARM) begin
                for (int v = 0; v < 2; v++)
                    if (pend_trig[v]) begin
                        env[v] = 16777216;
                        hold_cnt[v] = 0;
                    end
                pend_trig = 2'b00;
            end else if (mode == nbsg_pkg::MODE_SAMPLE) begin
                for (int v = 0; v < 2; v++)
                    if (env[v] != 0) total += voice_sample(v);
                total *= gain;
                if (total > 524287) total = 524287;
                if (total < -524288) total = -524288;
            end
            exp_audio.push_back(20'(total));
            exp_snd.push_back({env[1] != 0, env[0] != 0});
        endfunction

        function void check_result(logic signed [19:0] a, logic [1:0] s);
            if (exp_audio.size() == 0) begin
                $display("%0t: unexpected result audio=%0d sounding=%0d", $time, a, s);
                errors++;
                return;
            end
            if (a !== exp_audio[0]) begin
                $display("%0t: audio_out expected %0d actual %0d", $time, exp_audio[0], a);
                errors++;
            end
            if (s !== exp_snd[0]) begin
                $display("%0t: voices_sounding expected %0d actual %0d", $time, exp_snd[0], s);
                errors++;
            end
            void'(exp_audio.pop_front());
            void'(exp_snd.pop_front());
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          sent;
    longint      cycles;
    nbsg_scoreboard sb;

    nbsg_in_if  in_ch ();
    nbsg_out_if out_ch ();

    noise_burst_sound_generator_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch.sink),
        .o_out_ch(out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side: sample at rising edge, drive ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.audio_out, out_ch.voices_sounding);
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_gain(logic [3:0] g);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= 32'(g);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.gain = g;
    endtask

    // called at a falling edge; valid stays up into the next item unless the sender idles
    task automatic send_item(logic [1:0] mode, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.cmd_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(mode, b);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.exp_audio.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // a burst: mostly triggers, arm, then a run of samples with some stray command or none items; else one random item
    task automatic random_burst();
        int n;
        if ($urandom_range(9) == 0) send_item(2'($urandom_range(3)), 8'($urandom));
        else begin
            if ($urandom_range(2) != 0)
                send_item(nbsg_pkg::MODE_CMD, {nbsg_pkg::CMD_TRIG0, 4'($urandom)});
            if ($urandom_range(2) != 0)
                send_item(nbsg_pkg::MODE_CMD, {nbsg_pkg::CMD_TRIG1, 4'($urandom)});
            send_item(nbsg_pkg::MODE_ARM, 8'($urandom));
            n = $urandom_range(40, 5);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(7) == 0)
                    send_item($urandom_range(1) ? nbsg_pkg::MODE_CMD : nbsg_pkg::MODE_NONE,
                              8'($urandom));
                else send_item(nbsg_pkg::MODE_SAMPLE, 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [3:0] gains[4];
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.mode = nbsg_pkg::MODE_NONE;
        in_ch.cmd_byte = 8'd0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sample while silent, parameter skipping, unused nibbles, arm
        send_item(nbsg_pkg::MODE_SAMPLE, 8'hFF);
        send_item(nbsg_pkg::MODE_NONE, 8'hFF);
        send_item(nbsg_pkg::MODE_ARM, 8'h00);
        send_item(nbsg_pkg::MODE_CMD, 8'h3A);
        for (int i = 0; i < 4; i++) send_item(nbsg_pkg::MODE_CMD, 8'h1F);
        send_item(nbsg_pkg::MODE_CMD, 8'h40);
        for (int i = 0; i < 4; i++) send_item(nbsg_pkg::MODE_CMD, 8'h20);
        send_item(nbsg_pkg::MODE_CMD, 8'h65);
        for (int i = 0; i < 5; i++) send_item(nbsg_pkg::MODE_CMD, 8'h10);
        send_item(nbsg_pkg::MODE_CMD, 8'h00);
        send_item(nbsg_pkg::MODE_CMD, 8'h5F);
        send_item(nbsg_pkg::MODE_CMD, 8'hF0);
        send_item(nbsg_pkg::MODE_CMD, 8'h1F);
        send_item(nbsg_pkg::MODE_CMD, 8'h20);
        send_item(nbsg_pkg::MODE_ARM, 8'hAA);
        drain();
        write_gain(4'd15);
        for (int i = 0; i < 20; i++) send_item(nbsg_pkg::MODE_SAMPLE, 8'h55);
        drain();

        gains = '{4'd0, 4'd15, 4'd1, 4'd10};
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 56; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 56; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            write_gain(gains[p]);
            // at least 470 items per phase
            sent = 0;
            while (sent < 470) random_burst();
            drain();
        end

        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/nbsg_pkg.sv
rtl/nbsg_if.sv
rtl/nbsg_decoder.sv
rtl/nbsg_engine.sv
rtl/noise_burst_sound_generator_unit.sv
tb/sv/noise_burst_sound_generator_unit_tb.sv
